>>> rtl/tlr_pkg.sv
// ----------------------------------------------------------------------------
// tlr_pkg
// types and constants shared by the text line renderer
// ----------------------------------------------------------------------------
package tlr_pkg;

  localparam int CODE_W = 8;
  localparam int OFFS_W = 32;
  localparam int REP_W  = 7;
  localparam int TAB_W  = 7;
  localparam int CFG_W  = 7;
  localparam int CIDX_W = 2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_TAB_STOP  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_LIST_MODE = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_LIST_SUSP = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_PRINT     = 2'd3;

  localparam logic [TAB_W-1:0] TAB_STOP_RST = 7'd8;

  // character codes
  localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CODE_W-1:0] CH_FF    = 8'h0c;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CODE_W-1:0] CH_CARET = 8'h5e;
  localparam logic [CODE_W-1:0] CH_DEL   = 8'h7f;
  localparam logic [CODE_W-1:0] CTRL_LIM = 8'h20;
  localparam logic [CODE_W-1:0] CTRL_XOR = 8'h40;

  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic [OFFS_W-1:0] char_offset;
    logic              buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] glyph;
    logic [REP_W-1:0]  repeat_res;
    logic [OFFS_W-1:0] glyph_offset;
    logic              line_end;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EMIT0,
    ST_EMIT1,
    ST_WRAP
  } state_t;

endpackage

>>> rtl/text_line_renderer.sv
// ----------------------------------------------------------------------------
// text_line_renderer
// expands tabs into space runs outside list mode and renders control bytes in caret notation
// ----------------------------------------------------------------------------
//
//  channel   ports                         payload     direction
//  input     in_valid, in_stall, in_data   in_item_t   one text byte per request
//  result    out_valid, out_stall, out_data out_item_t one or two glyph runs per request
//  config    cfg_we, cfg_index, cfg_wdata  -           register writes
//
//  one request passes through accept, phase reduction, one or two glyph
//  steps and a phase wrap; the shared compare-and-subtract unit removes one
//  tab stop from the column phase per pass, in phase reduction up to
//  MAX_TAB_STOP - 1 passes when the tab stop has just been shrunk
//  reset returns the tab stop to 8, clears the modes and the column phase
//  a stalled result holds in the output register; the sequencer waits there
//
module text_line_renderer
  import tlr_pkg::*;
#(
  parameter int MAX_TAB_STOP = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  // phase holds up to MAX_TAB_STOP+1 before wrapping, and must hold any tab stop
  localparam int PH_BITS = $clog2(MAX_TAB_STOP + 2);
  localparam int CW      = (PH_BITS > TAB_W) ? PH_BITS : TAB_W;
  localparam logic [CW-1:0] MAX_TS = CW'(MAX_TAB_STOP);

  // configuration
  logic [TAB_W-1:0] tab_stop_r;
  logic             list_mode_r;
  logic             list_susp_r;
  logic             print_mode_r;

  // sequencer state
  state_t    state_r, state_nxt;
  in_item_t  item_r, item_nxt;
  logic [CW-1:0] phase_r, phase_nxt;
  logic [CODE_W-1:0] sec_r, sec_nxt;
  logic      sec_end_r, sec_end_nxt;
  logic      two_r, two_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  logic          listing;
  logic [CW-1:0] tab_ext;
  logic [CW-1:0] ts_eff;
  logic [CW-1:0] phase_sub;
  logic          phase_geq;
  logic          out_free;
  logic          is_ctrl;

  assign listing  = list_mode_r & ~list_susp_r;
  assign tab_ext  = CW'(tab_stop_r);
  assign out_free = ~out_valid_r | ~out_stall;
  assign is_ctrl  = (item_r.char_code < CTRL_LIM) || (item_r.char_code == CH_DEL);

  // effective tab stop: zero acts as one, large values saturate
  always_comb begin
    if (tab_stop_r == '0) begin
      ts_eff = CW'(1);
    end else if (tab_ext > MAX_TS) begin
      ts_eff = MAX_TS;
    end else begin
      ts_eff = tab_ext;
    end
  end

  // the shared unit: one compare and subtract of the tab stop per cycle
  assign phase_geq = (phase_r >= ts_eff);
  assign phase_sub = phase_r - ts_eff;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_stop_r   <= TAB_STOP_RST;
      list_mode_r  <= 1'b0;
      list_susp_r  <= 1'b0;
      print_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TAB_STOP:  tab_stop_r   <= cfg_wdata[TAB_W-1:0];
        CFG_LIST_MODE: list_mode_r  <= cfg_wdata[0];
        CFG_LIST_SUSP: list_susp_r  <= cfg_wdata[0];
        CFG_PRINT:     print_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    sec_r     <= sec_nxt;
    sec_end_r <= sec_end_nxt;
    two_r     <= two_nxt;
    out_r     <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    phase_nxt     = phase_r;
    sec_nxt       = sec_r;
    sec_end_nxt   = sec_end_r;
    two_nxt       = two_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_nxt       = out_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_REDUCE;
        end
      end

      // bring the phase below the current tab stop
      ST_REDUCE: begin
        if (phase_geq) begin
          phase_nxt = phase_sub;
        end else begin
          state_nxt = ST_EMIT0;
        end
      end

      // first glyph of the request and the new phase
      ST_EMIT0: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.glyph_offset  = item_r.char_offset;
          out_nxt.repeat_res    = REP_W'(1);
          out_nxt.line_end      = 1'b0;
          two_nxt               = 1'b0;
          sec_end_nxt           = 1'b0;
          sec_nxt               = CH_LF;
          if (item_r.buffer_end) begin
            out_nxt.glyph    = CH_LF;
            out_nxt.line_end = 1'b1;
            phase_nxt        = '0;
          end else if (item_r.char_code == CH_LF) begin
            phase_nxt = '0;
            if (listing) begin
              out_nxt.glyph = CH_DOLLAR;
              two_nxt       = 1'b1;
              sec_end_nxt   = 1'b1;
            end else begin
              out_nxt.glyph    = CH_LF;
              out_nxt.line_end = 1'b1;
            end
          end else if (item_r.char_code == CH_FF && print_mode_r) begin
            out_nxt.glyph    = CH_FF;
            out_nxt.line_end = 1'b1;
            phase_nxt        = '0;
          end else if (item_r.char_code == CH_TAB && !listing) begin
            // space run up to the next tab stop
            out_nxt.glyph      = CH_SPACE;
            out_nxt.repeat_res = REP_W'(ts_eff - phase_r);
            phase_nxt          = '0;
          end else if (is_ctrl) begin
            out_nxt.glyph = CH_CARET;
            sec_nxt       = item_r.char_code ^ CTRL_XOR;
            two_nxt       = 1'b1;
            phase_nxt     = phase_r + CW'(2);
          end else begin
            out_nxt.glyph = item_r.char_code;
            phase_nxt     = phase_r + CW'(1);
          end
          state_nxt = two_nxt ? ST_EMIT1 : ST_WRAP;
        end
      end

      // second glyph: caret letter, or the newline after a list mode '$'
      ST_EMIT1: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.glyph      = sec_r;
          out_nxt.repeat_res = REP_W'(1);
          out_nxt.line_end   = sec_end_r;
          state_nxt          = ST_WRAP;
        end
      end

      // reduce the advanced phase by the tab stop in force now
      ST_WRAP: begin
        if (phase_geq) begin
          phase_nxt = phase_sub;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
